// File: rtl/fpmd_pkg.sv
// fpmd_pkg: shared types and constants for the fixed-point multiply/divide unit.
// No dependencies; imported by every module of the unit.
`default_nettype none

package fpmd_pkg;

    localparam int DATA_W    = 32;   // operand and result width
    localparam int SAT_SHIFT = 14;   // divide overflow test shift

    typedef logic [DATA_W-1:0] word_t;

    // command codes
    localparam logic CMD_MUL = 1'b0;
    localparam logic CMD_DIV = 1'b1;

    // clamp values for divide overflow
    localparam word_t SAT_POS = 32'h7fff_ffff;
    localparam word_t SAT_NEG = 32'h8000_0000;

    // per-stage control carried alongside the data
    typedef struct packed {
        logic cmd_div;   // transaction is a divide
        logic differ;    // operand signs differ
        logic sat;       // divide clamps
    } ctl_t;

endpackage

`default_nettype wire

// File: rtl/fpmd_div_step.sv
// fpmd_div_step: one restoring-division step (one quotient bit).
// Depends on fpmd_pkg.
`default_nettype none

module fpmd_div_step
    import fpmd_pkg::*;
#(
    parameter int QW = 48
)
(
    input  word_t            rem_in,
    input  logic [QW-1:0]    dvd_in,
    input  word_t            divisor,
    output word_t            rem_out,
    output logic [QW-1:0]    dvd_out
);

    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            qbit;

    // trial stays below 2^32, so a borrow shows up in the top bit of diff
    assign trial   = {rem_in, dvd_in[QW-1]};
    assign diff    = trial - {1'b0, divisor};
    assign qbit    = ~diff[DATA_W];
    assign rem_out = qbit ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
    assign dvd_out = {dvd_in[QW-2:0], qbit};

endmodule

`default_nettype wire

// File: rtl/fixed_point_mul_div_unit_core.sv
// fixed_point_mul_div_unit_core: pipelined signed fixed-point multiply / divide.
// Depends on fpmd_pkg and fpmd_div_step.
//
//  channel | handshake           | payload
//  --------+---------------------+----------------------------------------
//  input   | in_valid / in_ready | command, operand_a, operand_b
//  output  | out_valid/out_ready | result_value, saturated
//
// Throughput is one transaction per cycle while the output skid entry is empty. The
// pipeline depth is set by the restoring divider: one quotient bit per pipeline
// stage, DATA_W + FRACTION_BITS bits. Multiplies ride the same pipeline so results
// leave in order. The pipeline advances as a whole while the output skid entry is
// empty; the skid entry catches the result that arrives while the output register
// is stalled, and in_ready drops once that entry is full.
// rst_n clears all valid bits; data registers are not reset.
`default_nettype none

module fixed_point_mul_div_unit_core
    import fpmd_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel
    input  wire logic               in_valid,
    output      logic               in_ready,
    input  wire logic               command,
    input  wire logic signed [31:0] operand_a,
    input  wire logic signed [31:0] operand_b,
    // output channel
    output      logic               out_valid,
    input  wire logic               out_ready,
    output      logic signed [31:0] result_value,
    output      logic               saturated
);

    localparam int QW = DATA_W + FRACTION_BITS;  // dividend / quotient width
    localparam int NP = QW + 2;                  // pipeline stages before the output

    // ------------------------------------------------------------------
    // Pipeline control: global advance gated by the skid entry
    // ------------------------------------------------------------------
    logic          adv;
    logic [NP-1:0] v_reg;
    logic          skid_v_reg;

    assign adv      = ~skid_v_reg;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NP-2:0], in_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: capture the transaction
    // ------------------------------------------------------------------
    logic  cmd0_reg;
    word_t a0_reg;
    word_t b0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmd0_reg <= command;
            a0_reg   <= operand_a;
            b0_reg   <= operand_b;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: multiply, magnitudes, overflow test
    // ------------------------------------------------------------------
    logic signed [2*DATA_W-1:0] prod;
    logic [DATA_W:0]            a_ext;
    logic [DATA_W:0]            b_ext;
    logic [DATA_W:0]            ma33;
    logic [DATA_W:0]            mb33;
    word_t                      ma;
    word_t                      mb;
    ctl_t                       ctl1;

    assign prod  = $signed(a0_reg) * $signed(b0_reg);
    assign a_ext = {a0_reg[DATA_W-1], a0_reg};
    assign b_ext = {b0_reg[DATA_W-1], b0_reg};
    assign ma33  = a0_reg[DATA_W-1] ? (~a_ext + 1'b1) : a_ext;
    assign mb33  = b0_reg[DATA_W-1] ? (~b_ext + 1'b1) : b_ext;
    // magnitudes top out at 2^31, which fits unsigned 32 bits
    assign ma    = ma33[DATA_W-1:0];
    assign mb    = mb33[DATA_W-1:0];

    always_comb
    begin
        ctl1.cmd_div = (cmd0_reg == CMD_DIV);
        ctl1.differ  = a0_reg[DATA_W-1] ^ b0_reg[DATA_W-1];
        // a zero divisor always lands here too
        ctl1.sat     = (cmd0_reg == CMD_DIV) && ((ma >> SAT_SHIFT) >= mb);
    end

    // per-stage data, index k sits in pipeline stage k+1
    ctl_t          ctl_reg [0:QW];
    word_t         mul_reg [0:QW];
    word_t         mb_reg  [0:QW-1];
    logic [QW-1:0] dvd_reg [0:QW-1];
    word_t         rem_reg [1:QW-1];
    word_t         quo_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[0] <= ctl1;
            mul_reg[0] <= prod[FRACTION_BITS+DATA_W-1:FRACTION_BITS];
            mb_reg[0]  <= mb;
            dvd_reg[0] <= {ma, {FRACTION_BITS{1'b0}}};
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: one quotient bit each
    // ------------------------------------------------------------------
    for (genvar k = 1; k < QW; k++)
    begin : g_div
        word_t         rem_in;
        word_t         rem_out;
        logic [QW-1:0] dvd_out;

        if (k == 1)
        begin : g_first
            assign rem_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
        end

        fpmd_div_step #(
            .QW (QW)
        ) u_step (
            .rem_in  (rem_in),
            .dvd_in  (dvd_reg[k-1]),
            .divisor (mb_reg[k-1]),
            .rem_out (rem_out),
            .dvd_out (dvd_out)
        );

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
                mul_reg[k] <= mul_reg[k-1];
                mb_reg[k]  <= mb_reg[k-1];
                dvd_reg[k] <= dvd_out;
                rem_reg[k] <= rem_out;
            end
        end
    end

    // last quotient bit: remainder no longer needed
    logic [DATA_W:0] last_trial;
    logic            last_bit;
    logic [QW-1:0]   quo_full;

    assign last_trial = {rem_reg[QW-1], dvd_reg[QW-1][QW-1]};
    assign last_bit   = (last_trial >= {1'b0, mb_reg[QW-1]});
    assign quo_full   = {dvd_reg[QW-1][QW-2:0], last_bit};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctl_reg[QW] <= ctl_reg[QW-1];
            mul_reg[QW] <= mul_reg[QW-1];
            quo_reg     <= quo_full[DATA_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Result select: sign fix, clamp, or product
    // ------------------------------------------------------------------
    word_t fin_value;
    logic  fin_sat;
    logic  fin_valid;

    always_comb
    begin
        fin_sat = ctl_reg[QW].sat;
        if (ctl_reg[QW].sat)
        begin
            fin_value = ctl_reg[QW].differ ? SAT_NEG : SAT_POS;
        end
        else if (ctl_reg[QW].cmd_div)
        begin
            fin_value = ctl_reg[QW].differ ? (~quo_reg + 1'b1) : quo_reg;
        end
        else
        begin
            fin_value = mul_reg[QW];
        end
    end

    assign fin_valid = v_reg[NP-1] & adv;

    // ------------------------------------------------------------------
    // Output register and skid entry
    // ------------------------------------------------------------------
    logic  out_v_reg;
    word_t out_value_reg;
    logic  out_sat_reg;
    word_t skid_value_reg;
    logic  skid_sat_reg;
    logic  take;

    assign take = ~out_v_reg | out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (take)
        begin
            out_v_reg  <= skid_v_reg | fin_valid;
            skid_v_reg <= 1'b0;
        end
        else if (fin_valid)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            if (skid_v_reg)
            begin
                out_value_reg <= skid_value_reg;
                out_sat_reg   <= skid_sat_reg;
            end
            else
            begin
                out_value_reg <= fin_value;
                out_sat_reg   <= fin_sat;
            end
        end
        else if (fin_valid)
        begin
            skid_value_reg <= fin_value;
            skid_sat_reg   <= fin_sat;
        end
    end

    assign out_valid    = out_v_reg;
    assign result_value = out_value_reg;
    assign saturated    = out_sat_reg;

endmodule

`default_nettype wire

// File: rtl/fpmd_checker.sv
// fpmd_checker: port-level assertions for fixed_point_mul_div_unit_core.
// Depends on fpmd_pkg; bound to the top level at the end of this file.
`default_nettype none

module fpmd_checker
    import fpmd_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               command,
    input wire logic signed [31:0] operand_a,
    input wire logic signed [31:0] operand_b,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic signed [31:0] result_value,
    input wire logic               saturated
);

    // stalled input transaction holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(command)
            && $stable(operand_a) && $stable(operand_b))
        else $error("input transaction changed while stalled");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_value)
            && $stable(saturated))
        else $error("result changed while stalled");

    // a clamped divide shows only the two limit values
    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> (result_value == SAT_POS || result_value == SAT_NEG))
        else $error("saturated result is not a limit value");

    // empty output stage means nothing is backed up
    a_ready_when_empty: assert property (@(posedge clk)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // draining a result frees the input side next cycle
    a_ready_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready)
        else $error("input still stalled after result taken");

endmodule

bind fixed_point_mul_div_unit_core fpmd_checker u_fpmd_checker (.*);

`default_nettype wire

// File: sim/testbench.sv
// testbench: self-checking bench for fixed_point_mul_div_unit_core (signed 16.16 mul/div).
// Depends on rtl/fpmd_pkg.sv and the core RTL; a queue-fed driver, a monitor and a
// behavioral predictor of the arithmetic check every result in order.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fpmd_pkg::*;

    localparam int FRAC_BITS   = 16;
    localparam int LATENCY     = DATA_W + FRAC_BITS + 3;  // pipeline depth of the core
    localparam int IDLE_PCT    = 11;                      // idle cycles per hundred, each side
    localparam int RANDOM_HALF = 400;                     // random transactions per phase
    localparam int HOLD_AT     = 170;                     // accepted count that starts the stall
    localparam int HOLD_CYCLES = 200;                     // long receiver stall, well past LATENCY
    localparam int QUIET_LO    = 450;                     // accepted-count window with no idling
    localparam int QUIET_HI    = 650;
    localparam int TIMEOUT_NS  = 2_000_000;               // timeout, far above a slow run

    // One input transaction: operation plus both operands.
    typedef struct packed {
        logic        cmd;
        logic [31:0] a;
        logic [31:0] b;
    } op_t;

    // One result transaction as the core should return it.
    typedef struct packed {
        logic [31:0] value;
        logic        sat;
    } outcome_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               command   = CMD_MUL;
    logic signed [31:0] operand_a = '0;
    logic signed [31:0] operand_b = '0;
    logic               out_ready = 1'b0;
    logic               in_ready;
    logic               out_valid;
    logic signed [31:0] result_value;
    logic               saturated;

    op_t      op_queue[$];         // transactions waiting to be offered
    outcome_t pending_results[$];  // predicted results, oldest first
    int       accepted_cnt = 0;    // input transactions taken by the core
    int       errors       = 0;
    int       hold_left    = 0;
    logic     hold_done    = 1'b0;

    // Both sides stop idling while the accepted count sits in this window.
    wire quiet = (accepted_cnt >= QUIET_LO) && (accepted_cnt < QUIET_HI);

    fixed_point_mul_div_unit_core #(
        .FRACTION_BITS (FRAC_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .operand_a    (operand_a),
        .operand_b    (operand_b),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .saturated    (saturated)
    );

    always #10 clk = ~clk;

    // Expected result of one transaction.
    // Multiply: exact 64-bit product, arithmetic shift by the fraction width, low word kept.
    // Divide: 33-bit magnitudes; clamp when |a| >> SAT_SHIFT reaches |b| (zero divisor
    // included), otherwise truncate the quotient toward zero and restore the sign.
    function automatic outcome_t predict_outcome(logic cmd, logic [31:0] a, logic [31:0] b);
        outcome_t           res;
        logic signed [63:0] product;
        logic        [32:0] mag_a;
        logic        [32:0] mag_b;
        logic        [63:0] quotient;
        logic               differ;
        res.sat = 1'b0;
        if (cmd == CMD_MUL) begin
            product   = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
            product   = product >>> FRAC_BITS;
            res.value = product[31:0];
        end
        else begin
            mag_a  = a[31] ? (~{1'b1, a} + 33'd1) : {1'b0, a};
            mag_b  = b[31] ? (~{1'b1, b} + 33'd1) : {1'b0, b};
            differ = a[31] ^ b[31];
            if ((mag_a >> SAT_SHIFT) >= mag_b || mag_b == '0) begin
                res.value = differ ? SAT_NEG : SAT_POS;
                res.sat   = 1'b1;
            end
            else begin
                quotient  = ({31'd0, mag_a} << FRAC_BITS) / {31'd0, mag_b};
                if (differ)
                    quotient = ~quotient + 64'd1;
                res.value = quotient[31:0];
            end
        end
        return res;
    endfunction

    // Driver: offers the queue head, holds it until the core takes it, and records the
    // prediction at the accepting edge. Valid is only dropped once the offered one is taken.
    always @(posedge clk or negedge rst_n)
    begin : drive_proc
        op_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_results.push_back(predict_outcome(command, operand_a, operand_b));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (op_queue.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT))
                begin
                    nxt       = op_queue.pop_front();
                    in_valid  <= 1'b1;
                    command   <= nxt.cmd;
                    operand_a <= nxt.a;
                    operand_b <= nxt.b;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure. Random idling, plus one long stall once traffic is flowing,
    // so the pipeline fills and in_ready has to drop while the driver keeps offering.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && accepted_cnt >= HOLD_AT)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_done <= 1'b1;
        end
        else
        begin
            out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: every accepted result is matched against the oldest prediction.
    always @(posedge clk)
    begin : check_proc
        outcome_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: value=%h saturated=%b",
                         $time, result_value, saturated);
            end
            else
            begin
                want = pending_results.pop_front();
                if (result_value !== want.value)
                begin
                    errors++;
                    $display("%0t: result_value expected %h actual %h",
                             $time, want.value, result_value);
                end
                if (saturated !== want.sat)
                begin
                    errors++;
                    $display("%0t: saturated expected %b actual %b",
                             $time, want.sat, saturated);
                end
            end
        end
    end

    task automatic add_op(logic cmd, logic [31:0] a, logic [31:0] b);
        op_queue.push_back('{cmd, a, b});
    endtask

    // Waits until the driver has nothing left to offer and every prediction has been met.
    task automatic wait_drained();
        while (op_queue.size() != 0 || in_valid || pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Random transactions: half multiplies, half divides. Operands mix full-range words,
    // small values, extremes and divisors placed right at the clamp threshold.
    task automatic queue_random(int count);
        logic        cmd;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] mag;
        logic [31:0] extremes[7];
        extremes = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff, 32'h7fff_ffff,
                     32'h8000_0000, 32'h0001_0000, 32'hffff_0000};
        for (int i = 0; i < count; i++)
        begin
            cmd = $urandom_range(1) ? CMD_DIV : CMD_MUL;
            case ($urandom_range(3))
                0, 1:    a = $urandom();
                2:       a = {{16{$urandom_range(1) == 1}}, 16'($urandom())};
                default: a = extremes[$urandom_range(6)];
            endcase
            case ($urandom_range(4))
                0, 1:    b = $urandom();
                2:       b = {{16{$urandom_range(1) == 1}}, 16'($urandom())};
                3:       b = extremes[$urandom_range(6)];
                default:
                begin
                    // divisor one below, at, or one above |a| >> SAT_SHIFT
                    mag = a[31] ? -a : a;
                    b   = (mag >> SAT_SHIFT) + $urandom_range(2) - 1;
                    if ($urandom_range(1))
                        b = -b;
                end
            endcase
            add_op(cmd, a, b);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // multiply corners: zero, one, full-scale, mixed signs, floor rounding of -1 * 1
        add_op(CMD_MUL, 32'h0000_0000, 32'h0000_0000);
        add_op(CMD_MUL, 32'h0001_0000, 32'h0001_0000);
        add_op(CMD_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
        add_op(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
        add_op(CMD_MUL, 32'h8000_0000, 32'h7fff_ffff);
        add_op(CMD_MUL, 32'hffff_ffff, 32'h0000_0001);
        add_op(CMD_MUL, 32'h0001_8000, 32'hfffd_c000);
        add_op(CMD_MUL, 32'h7fff_ffff, 32'hffff_ffff);
        // divide by zero with positive, negative and zero dividend
        add_op(CMD_DIV, 32'h0001_0000, 32'h0000_0000);
        add_op(CMD_DIV, 32'hffff_0000, 32'h0000_0000);
        add_op(CMD_DIV, 32'h0000_0000, 32'h0000_0000);
        // overflow threshold: |a| >> 14 == 16 clamps, a divisor of 17 does not
        add_op(CMD_DIV, 32'h0004_0000, 32'h0000_0010);
        add_op(CMD_DIV, 32'h0004_0000, 32'h0000_0011);
        add_op(CMD_DIV, 32'hfffc_0000, 32'h0000_0010);
        // most negative operand on either side, and clamps in both directions
        add_op(CMD_DIV, 32'h8000_0000, 32'h8000_0000);
        add_op(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
        add_op(CMD_DIV, 32'h8000_0000, 32'h0000_0001);
        add_op(CMD_DIV, 32'h7fff_ffff, 32'h7fff_ffff);
        add_op(CMD_DIV, 32'h7fff_ffff, 32'h8000_0000);
        // truncation toward zero on a negative quotient, zero dividend, mixed signs
        add_op(CMD_DIV, 32'hffff_ffff, 32'h0000_0003);
        add_op(CMD_DIV, 32'h0000_0000, 32'h0000_0001);
        add_op(CMD_DIV, 32'h0003_0000, 32'hfffe_0000);

        // sender pause: let the pipeline empty completely before random traffic
        wait_drained();
        queue_random(RANDOM_HALF);
        wait_drained();
        queue_random(RANDOM_HALF);
        wait_drained();

        // catch any stray result that trails the last expected one
        repeat (LATENCY + 8) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: fixed_point_mul_div_unit_core.f
rtl/fpmd_pkg.sv
rtl/fpmd_div_step.sv
rtl/fixed_point_mul_div_unit_core.sv
rtl/fpmd_checker.sv
sim/testbench.sv
